// ===== rtl/core/bi0_pkg.sv =====
// ============================================================================
// bi0_pkg
// Shared constants for the modified Bessel I0 pipeline: formats,
// polynomial coefficients and stage latencies.
// ============================================================================
package bi0_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 22;
    localparam int OUT_W         = 60;

    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0] ONE_Q56 = 64'h0100_0000_0000_0000;
    localparam logic [63:0] LN2_Q56 = 64'h00B1_7217_F7D1_CF7A;
    localparam logic [63:0] OUT_MAX = 64'h0FFF_FFFF_FFFF_FFFF;

    // small argument: c6..c1 then the constant term
    localparam logic [63:0] SMALL_COEF [7] = '{
        ((64'd45813    << 32) + 64'd5000000) / 64'd10000000,
        ((64'd360768   << 32) + 64'd5000000) / 64'd10000000,
        ((64'd2659732  << 32) + 64'd5000000) / 64'd10000000,
        ((64'd12067492 << 32) + 64'd5000000) / 64'd10000000,
        ((64'd30899424 << 32) + 64'd5000000) / 64'd10000000,
        ((64'd35156229 << 32) + 64'd5000000) / 64'd10000000,
        64'h0000_0001_0000_0000
    };

    // large argument: d8..d0
    localparam logic signed [63:0] LARGE_COEF [9] = '{
        ((64'd392377   << 32) + 64'd50000000) / 64'd100000000,
        64'd0 - (((64'd1647633 << 32) + 64'd50000000) / 64'd100000000),
        ((64'd2635537  << 32) + 64'd50000000) / 64'd100000000,
        64'd0 - (((64'd2057706 << 32) + 64'd50000000) / 64'd100000000),
        ((64'd916281   << 32) + 64'd50000000) / 64'd100000000,
        64'd0 - (((64'd157565  << 32) + 64'd50000000) / 64'd100000000),
        ((64'd225319   << 32) + 64'd50000000) / 64'd100000000,
        ((64'd1328592  << 32) + 64'd50000000) / 64'd100000000,
        ((64'd39894228 << 32) + 64'd50000000) / 64'd100000000
    };

    localparam int EXP_TERMS  = 20;
    localparam int MUL_LAT    = 2;
    localparam int CDIV_LAT   = MUL_LAT + 1;
    localparam int DIV_LAT    = 64;
    localparam int SQRT_LAT   = 32;
    localparam int KSPLIT_LAT = 7;
    localparam int SSTEP      = MUL_LAT + 1;
    localparam int LSTEP      = MUL_LAT + 2;
    localparam int ESTEP      = MUL_LAT + CDIV_LAT + 1;
    localparam int ESTEP_LAST = MUL_LAT + 1;

    localparam int T_TQ    = CDIV_LAT + MUL_LAT;
    localparam int T_SMALL = T_TQ + 6 * SSTEP;
    localparam int T_P     = DIV_LAT + 8 * LSTEP;
    localparam int T_E     = KSPLIT_LAT + (EXP_TERMS - 1) * ESTEP + ESTEP_LAST;
    localparam int T_M     = T_E + MUL_LAT;
    localparam int T_Q     = T_M + DIV_LAT;

endpackage

// ===== rtl/core/bessel_i0_approximation.sv =====
// ============================================================================
// bessel_i0_approximation
// Fixed-point modified Bessel I0: polynomial below 3.75, scaled asymptotic
// series with exp and sqrt above.
// ============================================================================
// Usage:
//   Input channel x_value/x_valid/x_ready carries a signed fixed-point
//   argument with FRAC_BITS fractional bits. Output channel
//   bessel_value/bessel_valid/bessel_ready returns I0 of it, unsigned, same
//   fractional bits, saturating at all ones.
//   Both branches are evaluated for every item; the result is selected at
//   the end. Throughput is one item per cycle while x_ready is high. The
//   depth is set by the 7-stage range reduction, the 20-term exp series
//   (each step a 2-stage 64x64 multiplier and, but in the last step, a
//   3-stage reciprocal divide), the 2-stage product with P(u) and the
//   64-stage restoring divide by sqrt.
//   Reset clears the valid bits only; no items are in flight afterwards.
//   When the receiver stalls with a result waiting, the whole pipeline holds;
//   a bubble in the last stage is still squeezed out. x_ready follows.
// ============================================================================
module bessel_i0_approximation
    import bi0_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [IN_W-1:0]  x_value,
    input  logic                    x_valid,
    output logic                    x_ready,
    output logic        [OUT_W-1:0] bessel_value,
    output logic                    bessel_valid,
    input  logic                    bessel_ready
);

    localparam int          SH   = 32 - FRAC_BITS;
    localparam logic [63:0] SRND = 64'd1 << (SH - 1);

    logic             en, out_load, last_valid;
    logic             v0_reg;
    logic [63:0]      a32_reg, a32_next;
    logic [IN_W-1:0]  mag;
    logic [T_Q-1:0]   vl_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_reg, out_next;

    // ---------------------------------------------------------------- control
    assign last_valid = vl_reg[T_Q-1];
    assign out_load   = !out_valid_reg || bessel_ready;
    assign en         = out_load || !last_valid;
    assign x_ready    = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            vl_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v0_reg <= x_valid;
                vl_reg <= {vl_reg[T_Q-2:0], v0_reg};
            end
            if (out_load)
            begin
                out_valid_reg <= last_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a32_reg <= a32_next;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign mag      = x_value[IN_W-1] ? (~x_value + 1'b1) : x_value;
    assign a32_next = 64'(mag) << SH;

    // ------------------------------------------------------------ small branch
    logic [63:0] tn_w, t_w, tq_w;
    logic [63:0] sacc_w [7];
    logic [63:0] stq_w  [6];
    logic [63:0] sround_w, small_d;

    assign tn_w = {a32_reg[61:0], 2'b00} + 64'd7;

    bi0_cdiv #(.DIV(15)) u_t (
        .clk (clk),
        .en  (en),
        .n   (tn_w),
        .q   (t_w)
    );

    bi0_mul #(.SHIFT(32), .RND(1'b1)) u_tq (
        .clk (clk),
        .en  (en),
        .a   (t_w),
        .b   (t_w),
        .p   (tq_w)
    );

    assign sacc_w[0] = SMALL_COEF[0];
    assign stq_w[0]  = tq_w;

    generate
        for (genvar j = 0; j < 6; j++) begin : g_small
            logic [63:0] prod;
            logic [63:0] acc_reg;

            bi0_mul #(.SHIFT(32), .RND(1'b1)) u_m (
                .clk (clk),
                .en  (en),
                .a   (sacc_w[j]),
                .b   (stq_w[j]),
                .p   (prod)
            );

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    acc_reg <= SMALL_COEF[j+1] + prod;
                end
            end

            assign sacc_w[j+1] = acc_reg;

            if (j < 5) begin : g_tq
                bi0_delay #(.W(64), .N(SSTEP)) u_d (
                    .clk (clk),
                    .en  (en),
                    .d   (stq_w[j]),
                    .q   (stq_w[j+1])
                );
            end
        end
    endgenerate

    assign sround_w = (sacc_w[6] + SRND) >> SH;

    bi0_delay #(.W(64), .N(T_Q - T_SMALL)) u_sd (
        .clk (clk),
        .en  (en),
        .d   (sround_w),
        .q   (small_d)
    );

    // ---------------------------------------------------- large branch: P(u)
    logic [63:0]        u_w;
    logic signed [63:0] pp_w [9];
    logic [63:0]        pu_w [8];
    logic [63:0]        pclamp_w, p_d;

    bi0_div u_udiv (
        .clk (clk),
        .en  (en),
        .hi  (64'd3),
        .lo  (64'd3 << 62),
        .d   (a32_reg),
        .q   (u_w)
    );

    assign pp_w[0] = LARGE_COEF[0];
    assign pu_w[0] = u_w;

    generate
        for (genvar j = 0; j < 8; j++) begin : g_poly
            logic        neg_reg, neg1_reg, neg2_reg;
            logic [63:0] mag_reg, u_reg, prod;
            logic signed [63:0] p_reg;

            bi0_mul #(.SHIFT(32), .RND(1'b1)) u_m (
                .clk (clk),
                .en  (en),
                .a   (mag_reg),
                .b   (u_reg),
                .p   (prod)
            );

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    neg_reg  <= pp_w[j][63];
                    mag_reg  <= pp_w[j][63] ? 64'(-pp_w[j]) : 64'(pp_w[j]);
                    u_reg    <= pu_w[j];
                    neg1_reg <= neg_reg;
                    neg2_reg <= neg1_reg;
                    p_reg    <= LARGE_COEF[j+1] + (neg2_reg ? -$signed(prod) : $signed(prod));
                end
            end

            assign pp_w[j+1] = p_reg;

            if (j < 7) begin : g_u
                bi0_delay #(.W(64), .N(LSTEP)) u_d (
                    .clk (clk),
                    .en  (en),
                    .d   (pu_w[j]),
                    .q   (pu_w[j+1])
                );
            end
        end
    endgenerate

    assign pclamp_w = pp_w[8][63] ? 64'd0 : 64'(pp_w[8]);

    bi0_delay #(.W(64), .N(T_E - T_P)) u_pd (
        .clk (clk),
        .en  (en),
        .d   (pclamp_w),
        .q   (p_d)
    );

    // --------------------------------------------- large branch: a = k*ln2 + r
    logic [63:0] ks_rem_w [8];
    logic [6:0]  ks_k_w   [8];
    logic [6:0]  k_d;

    assign ks_rem_w[0] = a32_reg << 24;
    assign ks_k_w[0]   = 7'd0;

    generate
        for (genvar j = 0; j < KSPLIT_LAT; j++) begin : g_ks
            localparam logic [63:0] STEP = LN2_Q56 << (KSPLIT_LAT - 1 - j);
            logic        ge;
            logic [63:0] rem_reg;
            logic [6:0]  k_reg;

            assign ge = ks_rem_w[j] >= STEP;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg <= ge ? ks_rem_w[j] - STEP : ks_rem_w[j];
                    k_reg   <= {ks_k_w[j][5:0], ge};
                end
            end

            assign ks_rem_w[j+1] = rem_reg;
            assign ks_k_w[j+1]   = k_reg;
        end
    endgenerate

    bi0_delay #(.W(7), .N(T_Q - KSPLIT_LAT)) u_kd (
        .clk (clk),
        .en  (en),
        .d   (ks_k_w[KSPLIT_LAT]),
        .q   (k_d)
    );

    // ------------------------------------------------- large branch: exp(r)
    logic [63:0] ee_w [EXP_TERMS+1];
    logic [63:0] er_w [EXP_TERMS];

    assign ee_w[0] = ONE_Q56;
    assign er_w[0] = ks_rem_w[KSPLIT_LAT];

    generate
        for (genvar j = 0; j < EXP_TERMS; j++) begin : g_exp
            localparam int IDX = EXP_TERMS - j;
            logic [63:0] prod, quo;
            logic [63:0] e_reg;

            bi0_mul #(.SHIFT(56), .RND(1'b1)) u_m (
                .clk (clk),
                .en  (en),
                .a   (er_w[j]),
                .b   (ee_w[j]),
                .p   (prod)
            );

            if (IDX >= 2) begin : g_div
                bi0_cdiv #(.DIV(IDX)) u_c (
                    .clk (clk),
                    .en  (en),
                    .n   (prod),
                    .q   (quo)
                );

                bi0_delay #(.W(64), .N(ESTEP)) u_d (
                    .clk (clk),
                    .en  (en),
                    .d   (er_w[j]),
                    .q   (er_w[j+1])
                );
            end
            else begin : g_nodiv
                assign quo = prod;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    e_reg <= ONE_Q56 + quo;
                end
            end

            assign ee_w[j+1] = e_reg;
        end
    endgenerate

    // -------------------------------------- large branch: sqrt, m, quotient
    logic [63:0] s_w, s_d, m_w, q_w;

    bi0_sqrt u_sqrt (
        .clk (clk),
        .en  (en),
        .v   (a32_reg << 26),
        .s   (s_w)
    );

    bi0_delay #(.W(64), .N(T_M - SQRT_LAT)) u_s_d (
        .clk (clk),
        .en  (en),
        .d   (s_w),
        .q   (s_d)
    );

    bi0_mul #(.SHIFT(32), .RND(1'b1)) u_m (
        .clk (clk),
        .en  (en),
        .a   (ee_w[EXP_TERMS]),
        .b   (p_d),
        .p   (m_w)
    );

    bi0_div u_qdiv (
        .clk (clk),
        .en  (en),
        .hi  (m_w >> 35),
        .lo  (m_w << 29),
        .d   (s_d),
        .q   (q_w)
    );

    // ------------------------------------------------------- branch select
    logic       small_f, sat_f, small_d_f, sat_d_f;
    logic [1:0] flags_d;

    assign small_f = a32_reg < (64'd15 << 30);
    assign sat_f   = a32_reg >= (64'd64 << 32);

    bi0_delay #(.W(2), .N(T_Q)) u_fd (
        .clk (clk),
        .en  (en),
        .d   ({small_f, sat_f}),
        .q   (flags_d)
    );

    assign small_d_f = flags_d[1];
    assign sat_d_f   = flags_d[0];

    logic signed [8:0] shv;
    logic [6:0]        nsh, psh;
    logic [63:0]       lg;

    always_comb
    begin
        shv = $signed({2'b00, k_d}) + $signed(9'(FRAC_BITS)) - 9'sd56;
        nsh = 7'(-shv);
        psh = shv[6:0];
        if (shv < 0)
        begin
            lg = (q_w + (64'd1 << (nsh - 7'd1))) >> nsh;
        end
        else if (shv == 0)
        begin
            lg = q_w;
        end
        else if (psh >= 7'd60 || q_w > (OUT_MAX >> psh))
        begin
            lg = OUT_MAX;
        end
        else
        begin
            lg = q_w << psh;
        end
        if (lg > OUT_MAX)
        begin
            lg = OUT_MAX;
        end

        if (sat_d_f)
        begin
            out_next = OUT_MAX[OUT_W-1:0];
        end
        else if (small_d_f)
        begin
            out_next = small_d[OUT_W-1:0];
        end
        else
        begin
            out_next = lg[OUT_W-1:0];
        end
    end

    assign bessel_value = out_reg;
    assign bessel_valid = out_valid_reg;

endmodule

// ===== rtl/core/bi0_delay.sv =====
// ============================================================================
// bi0_delay
// Enable-gated shift line that keeps operands aligned with the pipeline.
// ============================================================================
module bi0_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    generate
        if (N == 0) begin : g_none
            assign q = d;
        end
        else begin : g_line
            logic [W-1:0] sr_reg [N];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sr_reg[0] <= d;
                    for (int i = 1; i < N; i++)
                    begin
                        sr_reg[i] <= sr_reg[i-1];
                    end
                end
            end

            assign q = sr_reg[N-1];
        end
    endgenerate

endmodule

// ===== rtl/core/bi0_mul.sv =====
// ============================================================================
// bi0_mul
// Two-stage 64x64 multiplier returning the product shifted right by SHIFT,
// optionally rounded to nearest; four 32x32 partial products.
// ============================================================================
module bi0_mul #(
    parameter int SHIFT = 32,
    parameter bit RND   = 1'b1
) (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    localparam logic [127:0] RADD = RND ? (128'd1 << (SHIFT - 1)) : 128'd0;

    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    logic [63:0]  p_reg;
    logic [127:0] sum_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a[31:0]  * b[31:0];
            lh_reg <= a[31:0]  * b[63:32];
            hl_reg <= a[63:32] * b[31:0];
            hh_reg <= a[63:32] * b[63:32];
            p_reg  <= sum_next[SHIFT+63:SHIFT];
        end
    end

    always_comb
    begin
        sum_next = 128'(ll_reg) + (128'(lh_reg) << 32) + (128'(hl_reg) << 32)
                 + (128'(hh_reg) << 64) + RADD;
    end

    assign p = p_reg;

endmodule

// ===== rtl/core/bi0_cdiv.sv =====
// ============================================================================
// bi0_cdiv
// Floor division by a constant: reciprocal multiply, then one correction.
// ============================================================================
module bi0_cdiv #(
    parameter int DIV = 3
) (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] n,
    output logic [63:0] q
);

    localparam logic [64:0] RECIP_W = (65'd1 << 64) / 65'(DIV);
    localparam logic [63:0] RECIP   = RECIP_W[63:0];
    localparam logic [63:0] DV      = 64'(DIV);

    logic [63:0] q0_w;
    logic [63:0] n_d;
    logic [63:0] rem_w;
    logic [63:0] q_reg;

    bi0_mul #(.SHIFT(64), .RND(1'b0)) u_mul (
        .clk (clk),
        .en  (en),
        .a   (n),
        .b   (RECIP),
        .p   (q0_w)
    );

    bi0_delay #(.W(64), .N(2)) u_nd (
        .clk (clk),
        .en  (en),
        .d   (n),
        .q   (n_d)
    );

    assign rem_w = n_d - q0_w * DV;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q0_w + 64'(rem_w >= DV);
        end
    end

    assign q = q_reg;

endmodule

// ===== rtl/core/bi0_div.sv =====
// ============================================================================
// bi0_div
// Pipelined restoring divider: floor((hi:lo) / d), one quotient bit per
// stage, hi < d assumed.
// ============================================================================
module bi0_div (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] hi,
    input  logic [63:0] lo,
    input  logic [63:0] d,
    output logic [63:0] q
);

    logic [63:0] r_w  [65];
    logic [63:0] lo_w [65];
    logic [63:0] q_w  [65];
    logic [63:0] d_w  [65];

    assign r_w[0]  = hi;
    assign lo_w[0] = lo;
    assign q_w[0]  = 64'd0;
    assign d_w[0]  = d;

    generate
        for (genvar g = 0; g < 64; g++) begin : g_stage
            logic [64:0] r2;
            logic        ge;
            logic [64:0] diff;
            logic [63:0] r_reg, lo_reg, q_reg, d_reg;

            assign r2   = {r_w[g], lo_w[g][63]};
            assign ge   = r2 >= {1'b0, d_w[g]};
            assign diff = r2 - {1'b0, d_w[g]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg  <= ge ? diff[63:0] : r2[63:0];
                    lo_reg <= {lo_w[g][62:0], 1'b0};
                    q_reg  <= {q_w[g][62:0], ge};
                    d_reg  <= d_w[g];
                end
            end

            assign r_w[g+1]  = r_reg;
            assign lo_w[g+1] = lo_reg;
            assign q_w[g+1]  = q_reg;
            assign d_w[g+1]  = d_reg;
        end
    endgenerate

    assign q = q_w[64];

endmodule

// ===== rtl/core/bi0_sqrt.sv =====
// ============================================================================
// bi0_sqrt
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// ============================================================================
module bi0_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] v,
    output logic [63:0] s
);

    logic [63:0] v_w   [33];
    logic [63:0] res_w [33];

    assign v_w[0]   = v;
    assign res_w[0] = 64'd0;

    generate
        for (genvar g = 0; g < 32; g++) begin : g_stage
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
            logic [63:0] t;
            logic [63:0] v_reg, res_reg;

            assign t = res_w[g] + BIT;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (v_w[g] >= t)
                    begin
                        v_reg   <= v_w[g] - t;
                        res_reg <= (res_w[g] >> 1) + BIT;
                    end
                    else
                    begin
                        v_reg   <= v_w[g];
                        res_reg <= res_w[g] >> 1;
                    end
                end
            end

            assign v_w[g+1]   = v_reg;
            assign res_w[g+1] = res_reg;
        end
    endgenerate

    assign s = res_w[32];

endmodule
